FILE: design/assert_macros.svh
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk and off while i_rst_n is low.
`define AST_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and off while i_rst_n is low.
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ste_pkg.sv
// Package of the symbol table engine: widths, codes and beat types.
package ste_pkg;

    localparam int unsigned CAPACITY_DEF   = 64;
    localparam int unsigned KEY_BYTES_DEF  = 8;
    localparam int unsigned DATA_BYTES_DEF = 8;

    localparam int unsigned KEY_W   = 64;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned LEN_W   = 4;
    localparam int unsigned POS_W   = 6;
    localparam int unsigned HIDX_W  = 6;
    localparam int unsigned CNT_W   = 7;

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_UPSERT = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_LOOKUP = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_FULL = 3'd1,
        ST_OOB  = 3'd2,
        ST_MISS = 3'd3,
        ST_BIG  = 3'd4
    } t_status;

    typedef struct packed {
        t_kind              kind;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [LEN_W-1:0]   value_len;
        logic [POS_W-1:0]   position;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [HIDX_W-1:0]  hit_index;
        logic [VALUE_W-1:0] hit_value;
        logic [LEN_W-1:0]   hit_len;
        logic [CNT_W-1:0]   entry_count;
    } t_rsp;

    // Request fields after key normalization and data masking.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [LEN_W-1:0]   len;
        logic               big;
    } t_prep;

endpackage

FILE: design/ste_if.sv
// Valid/ready channel interfaces for the request and response beats.
interface ste_req_if import ste_pkg::*;;
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ste_rsp_if import ste_pkg::*;;
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: design/ste_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ste_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/ste_prep.sv
// Request front end: key normalization, data masking and length check.
module ste_prep import ste_pkg::*; #(
    parameter int unsigned KEY_BYTES  = KEY_BYTES_DEF,
    parameter int unsigned DATA_BYTES = DATA_BYTES_DEF
) (
    input  t_req  i_item,
    output t_prep o_prep
);

    always_comb begin
        logic alive;
        alive  = 1'b1;
        o_prep = '0;
        // The key is a string: bytes after the first zero byte do not count.
        for (int i = 0; i < 8; i++) begin
            if (i < KEY_BYTES) begin
                if (i_item.key[8*i +: 8] == 8'h00) begin
                    alive = 1'b0;
                end
                if (alive) begin
                    o_prep.key[8*i +: 8] = i_item.key[8*i +: 8];
                end
            end
        end
        // Bytes at or above the length are stored as zero.
        for (int i = 0; i < 8; i++) begin
            if (LEN_W'(i) < i_item.value_len) begin
                o_prep.value[8*i +: 8] = i_item.value[8*i +: 8];
            end
        end
        o_prep.len = i_item.value_len;
        o_prep.big = (i_item.value_len > LEN_W'(DATA_BYTES));
    end

endmodule

FILE: design/symbol_table_engine.sv
// Append, remove and rejected beats pass S_FIN (a remove S_MOVE) before the result is registered.
// Lookup and upsert scan first, comparing one stored key per cycle on the key memory read port:
// the scan runs from entry 0 upward and stops at the first hit, or ends after the last entry.
// One beat is in work at a time; the next is taken once the result sits in the output register.
// Reset (synchronous, active low) empties the table and the output register.
// The memories are not cleared: only entries below the count are ever read.
module symbol_table_engine import ste_pkg::*; #(
    parameter int unsigned CAPACITY   = CAPACITY_DEF,
    parameter int unsigned KEY_BYTES  = KEY_BYTES_DEF,
    parameter int unsigned DATA_BYTES = DATA_BYTES_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    ste_req_if.sink   i_req,
    ste_rsp_if.source o_rsp
);

    // Index width of the table, and count width (the count can reach CAPACITY).
    localparam int unsigned IW   = $clog2(CAPACITY);
    localparam int unsigned CW   = $clog2(CAPACITY + 1);
    localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;
    // Stored key width, stored data width, and the data memory word {len, data}.
    localparam int unsigned KW   = 8 * KEY_BYTES;
    localparam int unsigned VW   = 8 * DATA_BYTES;
    localparam int unsigned DW   = VW + LEN_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LOOK,
        S_FIN,
        S_MOVE
    } t_state;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_APPEND,
        ACT_UPDATE
    } t_act;

    // Control registers.
    t_state           r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_ovld, n_ovld;
    // Payload registers of the beat in work and of the response.
    t_kind            r_kind, n_kind;
    logic [KW-1:0]    r_key, n_key;
    logic [VW-1:0]    r_val, n_val;
    logic [LEN_W-1:0] r_len, n_len;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [IW-1:0]    r_scan, n_scan;
    logic [IW-1:0]    r_hidx, n_hidx;
    t_status          r_status, n_status;
    t_act             r_act, n_act;
    t_rsp             r_rsp, n_rsp;

    t_prep            prep;
    logic             acc;
    logic             out_free;
    logic             cnt_full;
    logic [IW-1:0]    last_idx;

    logic             key_we;
    logic [IW-1:0]    key_waddr;
    logic [KW-1:0]    key_wdata;
    logic [IW-1:0]    key_raddr;
    logic [KW-1:0]    key_rdata;
    logic             data_we;
    logic [IW-1:0]    data_waddr;
    logic [DW-1:0]    data_wdata;
    logic [IW-1:0]    data_raddr;
    logic [DW-1:0]    data_rdata;

    ste_prep #(
        .KEY_BYTES  (KEY_BYTES),
        .DATA_BYTES (DATA_BYTES)
    ) u_prep (
        .i_item (i_req.data),
        .o_prep (prep)
    );

    // Key memory: normalized symbols.
    ste_ram #(
        .WIDTH (KW),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (key_wdata),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    // Data memory: byte length above the masked data bytes.
    ste_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (data_waddr),
        .i_wdata (data_wdata),
        .i_raddr (data_raddr),
        .o_rdata (data_rdata)
    );

    // Beats are taken only between operations; the output register decouples the
    // response side, so a new beat may enter while the last result still waits.
    assign i_req.ready = (r_state == S_IDLE);
    assign acc         = i_req.valid && i_req.ready;
    assign out_free    = !r_ovld || o_rsp.ready;
    assign cnt_full    = (r_cnt >= CW'(CAPACITY));
    assign last_idx    = IW'(r_cnt - CW'(1));

    assign o_rsp.valid = r_ovld;
    assign o_rsp.data  = r_rsp;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_ovld     = r_ovld;
        n_kind     = r_kind;
        n_key      = r_key;
        n_val      = r_val;
        n_len      = r_len;
        n_pos      = r_pos;
        n_scan     = r_scan;
        n_hidx     = r_hidx;
        n_status   = r_status;
        n_act      = r_act;
        n_rsp      = r_rsp;

        key_we     = 1'b0;
        key_waddr  = IW'(r_cnt);
        key_wdata  = r_key;
        key_raddr  = '0;
        data_we    = 1'b0;
        data_waddr = IW'(r_cnt);
        data_wdata = {r_len, r_val};
        data_raddr = last_idx;

        if (r_ovld && o_rsp.ready) begin
            n_ovld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                // A remove reads the last entry now so it can be moved into the hole.
                key_raddr  = (i_req.data.kind == KIND_REMOVE) ? last_idx : '0;
                data_raddr = last_idx;
                if (acc) begin
                    n_kind   = i_req.data.kind;
                    n_key    = KW'(prep.key);
                    n_val    = VW'(prep.value);
                    n_len    = prep.len;
                    n_pos    = i_req.data.position;
                    n_scan   = '0;
                    n_hidx   = '0;
                    n_status = ST_OK;
                    n_act    = ACT_NONE;
                    unique case (i_req.data.kind)
                        KIND_APPEND, KIND_UPSERT: begin
                            // The length check comes before anything else.
                            if (prep.big) begin
                                n_status = ST_BIG;
                                n_state  = S_FIN;
                            end else if (i_req.data.kind == KIND_UPSERT && r_cnt != '0) begin
                                n_state = S_SCAN;
                            end else if (cnt_full) begin
                                n_status = ST_FULL;
                                n_state  = S_FIN;
                            end else begin
                                n_act   = ACT_APPEND;
                                n_state = S_FIN;
                            end
                        end
                        KIND_REMOVE: begin
                            if (CMPW'(i_req.data.position) >= CMPW'(r_cnt)) begin
                                n_status = ST_OOB;
                                n_state  = S_FIN;
                            end else begin
                                n_state = S_MOVE;
                            end
                        end
                        KIND_LOOKUP: begin
                            if (r_cnt == '0) begin
                                n_status = ST_MISS;
                                n_state  = S_FIN;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // The key of entry r_scan is on the read port; the next one is fetched.
                key_raddr  = r_scan + IW'(1);
                data_raddr = r_scan;
                if (key_rdata == r_key) begin
                    n_hidx = r_scan;
                    if (r_kind == KIND_LOOKUP) begin
                        n_state = S_LOOK;
                    end else begin
                        n_act   = ACT_UPDATE;
                        n_state = S_FIN;
                    end
                end else if (CW'(r_scan) + CW'(1) == r_cnt) begin
                    // No entry matches: a lookup misses, an upsert appends.
                    n_state = S_FIN;
                    if (r_kind == KIND_LOOKUP) begin
                        n_status = ST_MISS;
                    end else if (cnt_full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_act = ACT_APPEND;
                    end
                end else begin
                    n_scan = r_scan + IW'(1);
                end
            end

            S_LOOK: begin
                // The read address stays put so the data holds through a stall.
                data_raddr = r_hidx;
                if (out_free) begin
                    n_rsp.status      = ST_OK;
                    n_rsp.hit_index   = HIDX_W'(r_hidx);
                    n_rsp.hit_value   = VALUE_W'(data_rdata[VW-1:0]);
                    n_rsp.hit_len     = data_rdata[VW +: LEN_W];
                    n_rsp.entry_count = CNT_W'(r_cnt);
                    n_ovld            = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            S_FIN: begin
                if (out_free) begin
                    unique case (r_act)
                        ACT_APPEND: begin
                            key_we  = 1'b1;
                            data_we = 1'b1;
                            n_cnt   = r_cnt + CW'(1);
                        end
                        ACT_UPDATE: begin
                            data_we    = 1'b1;
                            data_waddr = r_hidx;
                        end
                        default: begin
                        end
                    endcase
                    n_rsp.status      = r_status;
                    n_rsp.hit_index   = HIDX_W'(r_hidx);
                    n_rsp.hit_value   = '0;
                    n_rsp.hit_len     = '0;
                    n_rsp.entry_count = CNT_W'(n_cnt);
                    n_ovld            = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            S_MOVE: begin
                // The last entry overwrites the removed one; the count shrinks.
                key_raddr  = last_idx;
                data_raddr = last_idx;
                if (out_free) begin
                    key_we     = 1'b1;
                    key_waddr  = IW'(r_pos);
                    key_wdata  = key_rdata;
                    data_we    = 1'b1;
                    data_waddr = IW'(r_pos);
                    data_wdata = data_rdata;
                    n_cnt      = r_cnt - CW'(1);
                    n_rsp.status      = ST_OK;
                    n_rsp.hit_index   = '0;
                    n_rsp.hit_value   = '0;
                    n_rsp.hit_len     = '0;
                    n_rsp.entry_count = CNT_W'(n_cnt);
                    n_ovld            = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovld  <= n_ovld;
        end
        r_kind   <= n_kind;
        r_key    <= n_key;
        r_val    <= n_val;
        r_len    <= n_len;
        r_pos    <= n_pos;
        r_scan   <= n_scan;
        r_hidx   <= n_hidx;
        r_status <= n_status;
        r_act    <= n_act;
        r_rsp    <= n_rsp;
    end

endmodule

FILE: design/ste_checker.sv
// Port-level assertions of the symbol table engine and their bind.
`include "assert_macros.svh"

module ste_checker import ste_pkg::*; #(
    parameter int unsigned CAPACITY   = CAPACITY_DEF,
    parameter int unsigned DATA_BYTES = DATA_BYTES_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp i_rsp_data
);

    logic             acc;
    logic [CNT_W-1:0] r_last_cnt;

    assign acc = i_rsp_valid && i_rsp_ready;

    // Entry count carried by the last delivered beat; the table starts empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_cnt <= '0;
        end else if (acc) begin
            r_last_cnt <= i_rsp_data.entry_count;
        end
    end

    `AST_NEXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_data), "response beat changed while stalled")
    `AST_IMPLY(a_cnt_step, acc, (i_rsp_data.entry_count == r_last_cnt) || (i_rsp_data.entry_count == r_last_cnt + CNT_W'(1)) || (i_rsp_data.entry_count + CNT_W'(1) == r_last_cnt), "entry count moved by more than one")
    `AST_IMPLY(a_miss_clear, acc && i_rsp_data.status == ST_MISS, i_rsp_data.hit_index == '0 && i_rsp_data.hit_value == '0 && i_rsp_data.hit_len == '0, "miss carries hit data")
    `AST_IMPLY(a_full_cnt, acc && i_rsp_data.status == ST_FULL, i_rsp_data.entry_count == CNT_W'(CAPACITY), "table full below capacity")
    `AST_IMPLY(a_len_range, acc, i_rsp_data.hit_len <= LEN_W'(DATA_BYTES), "hit length above data bytes")

endmodule

bind symbol_table_engine ste_checker #(
    .CAPACITY   (CAPACITY),
    .DATA_BYTES (DATA_BYTES)
) u_ste_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

FILE: verif/tb_symbol_table_engine.sv
// Self-checking testbench for the symbol table engine: directed and random table traffic.
module tb_symbol_table_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import ste_pkg::*;

    // Table geometry of the default build.
    localparam int unsigned DEPTH       = CAPACITY_DEF;
    localparam int unsigned KEY_LEN     = KEY_BYTES_DEF;
    localparam int unsigned DATA_LEN    = DATA_BYTES_DEF;
    // About 1350 request beats in all: a short directed opening, then random batches.
    localparam int unsigned RANDOM_BEATS = 1330;
    localparam int unsigned BATCH_LEN    = 19;
    // The limit leaves a wide margin over the slowest legal run (every beat a full-table
    // scan plus the longest gap on both sides).
    localparam int unsigned CYCLE_LIMIT  = 1_200_000;
    localparam int unsigned PRINT_CAP    = 40;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ste_req_if req_bus ();
    ste_rsp_if rsp_bus ();

    symbol_table_engine DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the table. Only entries below table_count are ever read,
    // both by the prediction and by the key picker of the stimulus.
    logic [KEY_W-1:0]   table_keys [DEPTH];
    logic [VALUE_W-1:0] table_data [DEPTH];
    logic [LEN_W-1:0]   table_lens [DEPTH];
    int unsigned        table_count = 0;

    t_req pending_reqs [$];     // request beats waiting for the driver
    t_rsp expected_rsps [$];    // predicted result beats, oldest first

    logic [KEY_W-1:0] name_pool [16];

    int unsigned mismatch_count = 0;
    int unsigned rsp_beats      = 0;
    int unsigned cycle_count    = 0;
    int unsigned kind_seen [4];
    int unsigned status_seen [8];

    // When calm is set, neither side inserts idle cycles for the current batch.
    bit          calm = 1'b0;
    int unsigned hold_left  = 0;
    int unsigned stall_left = 0;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // First entry below the count whose stored key equals k.
    function automatic bit locate_key(input logic [KEY_W-1:0] k, output int idx);
        idx = 0;
        for (int i = 0; i < int'(table_count); i++) begin
            if (table_keys[i] == k) begin
                idx = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Applies one accepted request beat to the shadow table and returns the
    // result beat the engine must produce for it.
    function automatic t_rsp apply_request(input t_req rq);
        t_rsp               rs;
        logic [KEY_W-1:0]   k;
        logic [VALUE_W-1:0] v;
        bit                 stop;
        bit                 found;
        int                 idx;

        rs    = '0;
        k     = '0;
        stop  = 1'b0;
        found = 1'b0;
        idx   = 0;

        // Keys compare as C strings: bytes from the first zero byte on are dropped.
        for (int b = 0; b < int'(KEY_LEN); b++) begin
            if (rq.key[b*8 +: 8] == 8'h00) stop = 1'b1;
            if (!stop) k[b*8 +: 8] = rq.key[b*8 +: 8];
        end

        // Data bytes at or above the length are stored as zero.
        if (rq.value_len >= DATA_LEN) v = rq.value;
        else v = rq.value & ((64'd1 << (rq.value_len * 8)) - 64'd1);

        kind_seen[rq.kind]++;
        rs.status = ST_OK;

        case (rq.kind)
            KIND_APPEND, KIND_UPSERT: begin
                // The length check comes before any search or capacity check.
                if (rq.value_len > DATA_LEN) begin
                    rs.status = ST_BIG;
                end else begin
                    if (rq.kind == KIND_UPSERT) found = locate_key(k, idx);
                    if (found) begin
                        table_data[idx] = v;
                        table_lens[idx] = rq.value_len;
                        rs.hit_index    = idx[HIDX_W-1:0];
                    end else if (table_count >= DEPTH) begin
                        rs.status = ST_FULL;
                    end else begin
                        table_keys[table_count] = k;
                        table_data[table_count] = v;
                        table_lens[table_count] = rq.value_len;
                        table_count++;
                    end
                end
            end
            KIND_REMOVE: begin
                // The last entry fills the hole; removing the last entry is a plain shrink.
                if (rq.position >= table_count) begin
                    rs.status = ST_OOB;
                end else begin
                    table_count--;
                    table_keys[rq.position] = table_keys[table_count];
                    table_data[rq.position] = table_data[table_count];
                    table_lens[rq.position] = table_lens[table_count];
                end
            end
            default: begin
                if (locate_key(k, idx)) begin
                    rs.hit_index = idx[HIDX_W-1:0];
                    rs.hit_value = table_data[idx];
                    rs.hit_len   = table_lens[idx];
                end else begin
                    rs.status = ST_MISS;
                end
            end
        endcase

        rs.entry_count = table_count[CNT_W-1:0];
        status_seen[rs.status]++;
        return rs;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_CAP) $display("ERROR at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("result beat %0d: %s is 0x%0h, expected 0x%0h",
                                      rsp_beats, name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Idle pattern shared by both sides: mostly back to back, some short
    // gaps and a few long ones.
    // ------------------------------------------------------------------

    function automatic int unsigned pick_pause();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    // ------------------------------------------------------------------
    // Request driver: takes beats from pending_reqs, holds each one until
    // the engine accepts it, and predicts its result at acceptance.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
            hold_left = 0;
        end else begin
            if (req_bus.valid && req_bus.ready)
                expected_rsps.push_back(apply_request(req_bus.data));
            // A new beat may go out only once the current one is gone.
            if (!req_bus.valid || req_bus.ready) begin
                if (hold_left > 0) begin
                    hold_left--;
                    req_bus.valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    req_bus.data  <= pending_reqs.pop_front();
                    req_bus.valid <= 1'b1;
                    hold_left = pick_pause();
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: stalls ready at random and checks every accepted
    // result beat against the oldest prediction.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (expected_rsps.size() == 0) begin
                    report_mismatch($sformatf("result beat %0d arrived with none expected",
                                              rsp_beats));
                end else begin
                    want = expected_rsps.pop_front();
                    check_field("status",      64'(rsp_bus.data.status),      64'(want.status));
                    check_field("hit_index",   64'(rsp_bus.data.hit_index),   64'(want.hit_index));
                    check_field("hit_value",   rsp_bus.data.hit_value,        want.hit_value);
                    check_field("hit_len",     64'(rsp_bus.data.hit_len),     64'(want.hit_len));
                    check_field("entry_count", 64'(rsp_bus.data.entry_count), 64'(want.entry_count));
                end
                rsp_beats++;
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= 1'b1;
                stall_left = pick_pause();
            end
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("ERROR: no progress after %0d cycles, %0d results still expected",
                     CYCLE_LIMIT, expected_rsps.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic queue_item(input t_kind kind, input logic [KEY_W-1:0] key,
                              input logic [VALUE_W-1:0] value,
                              input logic [LEN_W-1:0] len, input logic [POS_W-1:0] pos);
        t_req rq;
        rq.kind      = kind;
        rq.key       = key;
        rq.value     = value;
        rq.value_len = len;
        rq.position  = pos;
        pending_reqs.push_back(rq);
    endtask

    // Keys mostly come from the table itself or from a small name pool so that
    // searches hit often. Short keys sometimes get junk after their terminator,
    // which the engine must ignore.
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        int unsigned      r;
        int               nb;
        r = $urandom_range(0, 99);
        if (r < 55 && table_count > 0) k = table_keys[$urandom_range(0, table_count - 1)];
        else if (r < 85) k = name_pool[$urandom_range(0, 15)];
        else return {$urandom, $urandom};
        nb = 0;
        while (nb < 8 && k[nb*8 +: 8] != 8'h00) nb++;
        if (nb < 7 && $urandom_range(0, 2) == 0) begin
            for (int b = nb + 1; b < 8; b++) k[b*8 +: 8] = 8'($urandom);
        end
        return k;
    endfunction

    // One random beat; the weights are percentages, lookup takes the rest.
    task automatic queue_random(input int unsigned w_app, input int unsigned w_ups,
                                input int unsigned w_rem);
        t_kind       kind;
        int unsigned r;
        logic [LEN_W-1:0] len;
        logic [POS_W-1:0] pos;
        r = $urandom_range(0, 99);
        if (r < w_app) kind = KIND_APPEND;
        else if (r < w_app + w_ups) kind = KIND_UPSERT;
        else if (r < w_app + w_ups + w_rem) kind = KIND_REMOVE;
        else kind = KIND_LOOKUP;
        // Oversized lengths are rare so that most writes land.
        if ($urandom_range(0, 11) == 0) len = LEN_W'($urandom_range(DATA_LEN + 1, 15));
        else len = LEN_W'($urandom_range(0, DATA_LEN));
        // Removes mostly target a live entry; the rest may fall past the end.
        if (table_count > 0 && $urandom_range(0, 4) != 0)
            pos = POS_W'($urandom_range(0, table_count - 1));
        else
            pos = POS_W'($urandom);
        queue_item(kind, pick_key(), {$urandom, $urandom}, len, pos);
    endtask

    initial begin
        // Symbolic keys: "sym", eight 0xFF bytes, "counter".
        logic [KEY_W-1:0] key_sym;
        logic [KEY_W-1:0] key_ones;
        logic [KEY_W-1:0] key_ctr;
        int unsigned      made;
        bit               filling;
        bit               at_full;
        int unsigned      nlen;

        req_bus.valid = 1'b0;
        req_bus.data  = '0;
        rsp_bus.ready = 1'b0;
        i_rst_n       = 1'b0;

        key_sym  = 64'h0000_0000_006D_7973;
        key_ones = '1;
        key_ctr  = 64'h0072_6574_6E75_6F63;

        // Name pool: nonzero strings of one to eight bytes.
        foreach (name_pool[i]) begin
            name_pool[i] = '0;
            nlen = $urandom_range(1, KEY_LEN);
            for (int b = 0; b < int'(nlen); b++) name_pool[i][b*8 +: 8] = 8'($urandom_range(1, 255));
        end

        // Directed opening, starting from the empty table.
        queue_item(KIND_LOOKUP, key_sym,  '0, 4'd0,  6'd0);              // search of an empty table
        queue_item(KIND_REMOVE, key_sym,  '0, 4'd0,  6'd0);              // remove from an empty table
        queue_item(KIND_APPEND, key_sym,  '1, 4'd0,  6'd0);              // zero-length data
        queue_item(KIND_APPEND, key_ones, {$urandom, $urandom}, 4'd8, 6'd63);
        queue_item(KIND_APPEND, key_ctr,  '1, 4'd9,  6'd0);              // one byte too long
        queue_item(KIND_UPSERT, key_sym,  '1, 4'd15, 6'd0);              // too long even on a hit
        queue_item(KIND_UPSERT, key_sym,  '1, 4'd3,  6'd0);              // overwrite in place
        queue_item(KIND_LOOKUP, 64'hA5C3_0F11_006D_7973, '0, 4'd0, 6'd0); // junk after terminator
        queue_item(KIND_APPEND, '0, {$urandom, $urandom}, 4'd8, 6'd0);   // empty-string key
        queue_item(KIND_LOOKUP, 64'hFFEE_DDCC_BBAA_9900, '0, 4'd0, 6'd0); // also the empty string
        queue_item(KIND_UPSERT, key_ctr,  {$urandom, $urandom}, 4'd5, 6'd0); // miss, so appended
        queue_item(KIND_APPEND, key_sym,  {$urandom, $urandom}, 4'd8, 6'd0); // duplicate key
        queue_item(KIND_LOOKUP, key_sym,  '0, 4'd0,  6'd0);              // first match wins
        queue_item(KIND_REMOVE, key_sym,  '0, 4'd0,  6'd0);              // last entry moves to 0
        queue_item(KIND_LOOKUP, key_sym,  '0, 4'd0,  6'd0);              // now finds the moved one
        queue_item(KIND_REMOVE, key_sym,  '0, 4'd0,  6'd63);             // far past the end
        queue_item(KIND_REMOVE, key_sym,  '0, 4'd0,  6'd4);              // exactly at the count
        queue_item(KIND_REMOVE, key_sym,  '0, 4'd0,  6'd3);              // remove the last entry
        queue_item(KIND_LOOKUP, key_ctr,  '0, 4'd0,  6'd0);              // gone
        queue_item(KIND_LOOKUP, key_ones, '0, 4'd0,  6'd0);
        queue_item(KIND_UPSERT, key_ones, '1, 4'd1,  6'd0);
        queue_item(KIND_LOOKUP, key_ones, '0, 4'd0,  6'd0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Random part in batches. Each batch is built from the exact table state
        // after the previous one, so fill batches grow the table to capacity
        // (and then bounce off it), drain batches empty it again, and random mixed
        // beats within them stir it at whatever level it has. The driver state is sampled
        // on the falling edge, after everything the rising edge changed.
        made    = 0;
        filling = 1'b1;
        while (made < RANDOM_BEATS) begin
            while (pending_reqs.size() != 0 || req_bus.valid) @(negedge i_clk);
            calm <= ($urandom_range(0, 3) == 0);
            at_full = (table_count == DEPTH);
            if (table_count <= 2) filling = 1'b1;
            for (int i = 0; i < int'(BATCH_LEN); i++) begin
                if (!at_full && $urandom_range(0, 3) == 0) queue_random(25, 25, 25);
                else if (filling || at_full) queue_random(55, 25, 5);
                else queue_random(10, 10, 55);
            end
            if (at_full) filling = 1'b0;
            made += BATCH_LEN;
        end

        // Drain: every beat accepted, every result in, then a quiet tail long
        // enough for a full scan so that a stray extra result would show up.
        while (pending_reqs.size() != 0 || req_bus.valid) @(negedge i_clk);
        while (expected_rsps.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);

        $display("Run covered %0d request beats: %0d append, %0d upsert, %0d remove, %0d lookup.",
                 rsp_beats, kind_seen[KIND_APPEND], kind_seen[KIND_UPSERT],
                 kind_seen[KIND_REMOVE], kind_seen[KIND_LOOKUP]);
        $display("Outcomes: %0d ok, %0d full, %0d out of range, %0d miss, %0d too long; %0d mismatches.",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_OOB],
                 status_seen[ST_MISS], status_seen[ST_BIG], mismatch_count);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
